// ===== rtl/cle_pkg.sv =====
// ----------------------------------------------------------------------------
// cle_pkg - shared types and constants for the console line editor
// Line store sizing, control characters, result kinds and the echo table.
// ----------------------------------------------------------------------------
package cle_pkg;

  localparam int LINE_DEPTH = 32;
  localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int CNT_W      = 5;
  localparam int CAP_W      = 6;
  // Longest line ever held: one slot short of the store, and the length field.
  localparam int LIMIT_MAX  = (LINE_DEPTH - 1 < 31) ? LINE_DEPTH - 1 : 31;

  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_ESC = 8'h1B;
  localparam logic [7:0] CH_SP  = 8'h20;

  localparam logic [1:0] KIND_ECHO = 2'd0;
  localparam logic [1:0] KIND_LINE = 2'd1;
  localparam logic [1:0] KIND_MARK = 2'd2;

  localparam logic [CNT_W-1:0] ECHO_LEN = CNT_W'(3);

  typedef struct packed {
    logic             valid;
    logic [1:0]       kind;
    logic [7:0]       data;
    logic [CNT_W-1:0] len;
    logic             last;
  } cle_res_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } cle_wr_t;

  typedef struct packed {
    logic             idle;
    logic [CNT_W-1:0] count;
  } cle_status_t;

  // Echo sequences: rubout is BS SP BS, line end is CR CR LF.
  function automatic logic [7:0] echo_char(input logic is_eol, input logic [CNT_W-1:0] step);
    logic [7:0] ch;
    if (is_eol) begin
      ch = (step == ECHO_LEN - CNT_W'(1)) ? CH_LF : CH_CR;
    end else begin
      ch = (step == CNT_W'(1)) ? CH_SP : CH_BS;
    end
    return ch;
  endfunction

endpackage

// ===== rtl/console_line_editor.sv =====
// ----------------------------------------------------------------------------
// console_line_editor - serial console line editor
// Edits one console line from received bytes, echoes to the terminal and
// hands out each completed line followed by an end marker.
// ----------------------------------------------------------------------------
// Each received byte is one request on the slave stream; the block then shows
// its results one per cycle, while the output register is free, on the master
// stream and takes no new byte until the last of them has been loaded into
// the output register. The sequencer steps one result per cycle through the
// shared step unit and the single read port of the line store, which is read
// one entry ahead of the result shown.
// The store needs no clearing: only entries below the fill count are read.
// ----------------------------------------------------------------------------
module console_line_editor
  import cle_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  // request stream
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,   // [7:0] rx_byte
  // result stream
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [7:0] out_byte, [12:8] line_length, zero pad
  output logic [1:0]       m_axis_tuser,   // [1:0] kind
  output logic             m_axis_tlast,
  // line_capacity register
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CAP_W-1:0] cfg_data
);

  logic [CAP_W-1:0]  line_capacity;
  logic [CAP_W-1:0]  cap_m1;
  logic [CNT_W-1:0]  limit;
  logic              out_free;
  cle_res_t          res;
  cle_wr_t           wr;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;
  cle_status_t       status;

  // Capacity register; always ready, the limit only matters when a request
  // is taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_capacity <= CAP_W'(32);
    end else if (cfg_valid) begin
      line_capacity <= cfg_data;
    end
  end

  // Storage limit: capacity less the terminator slot, clamped to the store
  always_comb begin
    cap_m1 = (line_capacity == '0) ? '0 : line_capacity - CAP_W'(1);
    if (cap_m1 > CAP_W'(LIMIT_MAX)) begin
      limit = CNT_W'(LIMIT_MAX);
    end else begin
      limit = cap_m1[CNT_W-1:0];
    end
  end

  cle_line_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  cle_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_byte  (s_axis_tdata),
    .limit    (limit),
    .out_free (out_free),
    .rd_data  (rd_data),
    .res      (res),
    .wr       (wr),
    .rd_addr  (rd_addr),
    .status   (status)
  );

  assign s_axis_tready = status.idle;

  // Output register: loads when empty or being drained
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res.valid) begin
      m_axis_tdata <= {3'b000, res.len, res.data};
      m_axis_tuser <= res.kind;
      m_axis_tlast <= res.last;
    end
  end

  // Checks
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    status.count <= CNT_W'(LIMIT_MAX))
    else $error("line fill count beyond store limit");

  a_mark_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == KIND_MARK) |-> m_axis_tlast)
    else $error("end marker not flagged as final result");

  a_len_mark_only: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser != KIND_MARK) |-> (m_axis_tdata[12:8] == '0))
    else $error("length set on a non-marker result");

  a_busy_results: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> !s_axis_tready)
    else $error("request taken while results pending");

endmodule

// ===== rtl/cle_step_unit.sv =====
// ----------------------------------------------------------------------------
// cle_step_unit - shared increment and compare
// One incrementer with an equal and a less-than compare, reused for the fill
// check, echo steps and the line walk.
// ----------------------------------------------------------------------------
module cle_step_unit
  import cle_pkg::*;
(
  input  logic [CNT_W-1:0] op_a,
  input  logic [CNT_W-1:0] op_b,
  output logic [CNT_W-1:0] inc,
  output logic             inc_eq,
  output logic             lt
);

  logic [CNT_W:0] sum;

  assign sum    = {1'b0, op_a} + (CNT_W+1)'(1);
  assign inc    = sum[CNT_W-1:0];
  assign inc_eq = (sum == {1'b0, op_b});
  assign lt     = (op_a < op_b);

endmodule

// ===== rtl/cle_line_store.sv =====
// ----------------------------------------------------------------------------
// cle_line_store - line byte memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module cle_line_store
  import cle_pkg::*;
(
  input  logic              clk,
  input  cle_wr_t           wr,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [LINE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/cle_sequencer.sv =====
// ----------------------------------------------------------------------------
// cle_sequencer - request decode and result sequencing
// Decodes each received byte and steps through its echo, line walk and end
// marker, one result per cycle while the output register is free, through the shared step unit.
// ----------------------------------------------------------------------------
module cle_sequencer
  import cle_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [7:0]        in_byte,
  input  logic [CNT_W-1:0]  limit,
  input  logic              out_free,
  input  logic [7:0]        rd_data,
  output cle_res_t          res,
  output cle_wr_t           wr,
  output logic [ADDR_W-1:0] rd_addr,
  output cle_status_t       status
);

  typedef enum logic [2:0] {S_IDLE, S_CHAR, S_ECHO, S_LINE, S_MARK} state_t;

  state_t           state;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] idx;
  logic [7:0]       byte_q;
  logic             echo_eol;
  logic             cr_seen;

  logic [CNT_W-1:0] op_a, op_b, inc;
  logic             inc_eq, lt;
  logic             accept, take;
  logic             is_bs, is_eol, is_swallow;

  cle_step_unit u_step (
    .op_a   (op_a),
    .op_b   (op_b),
    .inc    (inc),
    .inc_eq (inc_eq),
    .lt     (lt)
  );

  assign accept     = in_valid && (state == S_IDLE);
  assign take       = res.valid && out_free;
  assign is_bs      = (in_byte == CH_BS);
  assign is_swallow = (in_byte == CH_LF) && cr_seen;
  assign is_eol     = (in_byte == CH_CR) || (in_byte == CH_LF) || (in_byte == CH_ESC);

  // Operand select for the shared unit
  always_comb begin
    unique case (state)
      S_IDLE:  begin op_a = count; op_b = limit;    end
      S_ECHO:  begin op_a = idx;   op_b = ECHO_LEN; end
      S_LINE:  begin op_a = idx;   op_b = count;    end
      default: begin op_a = idx;   op_b = count;    end
    endcase
  end

  always_comb begin
    res = '0;
    unique case (state)
      S_IDLE: ;
      S_CHAR: begin
        res.valid = 1'b1;
        res.kind  = KIND_ECHO;
        res.data  = byte_q;
        res.last  = 1'b1;
      end
      S_ECHO: begin
        res.valid = 1'b1;
        res.kind  = KIND_ECHO;
        res.data  = echo_char(echo_eol, idx);
        res.last  = !echo_eol && inc_eq;
      end
      S_LINE: begin
        res.valid = 1'b1;
        res.kind  = KIND_LINE;
        res.data  = rd_data;
      end
      S_MARK: begin
        res.valid = 1'b1;
        res.kind  = KIND_MARK;
        res.len   = count;
        res.last  = 1'b1;
      end
      default: ;
    endcase
  end

  // Ordinary byte stored at the fill position
  always_comb begin
    wr.en   = accept && !is_bs && !is_swallow && !is_eol && lt;
    wr.addr = ADDR_W'(count);
    wr.data = in_byte;
  end

  // Prefetch: the entry shown next is read in the cycle before it is shown
  always_comb begin
    if (state == S_LINE) begin
      rd_addr = take ? ADDR_W'(inc) : ADDR_W'(idx);
    end else begin
      rd_addr = '0;
    end
  end

  assign status.idle  = (state == S_IDLE);
  assign status.count = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      cr_seen  <= 1'b0;
      idx      <= '0;
      echo_eol <= 1'b0;
      byte_q   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            idx <= '0;
            priority if (is_bs) begin
              if (count != '0) begin
                count    <= count - CNT_W'(1);
                echo_eol <= 1'b0;
                state    <= S_ECHO;
              end
            end else if (is_swallow) begin
              cr_seen <= 1'b0;
            end else if (is_eol) begin
              if (in_byte == CH_CR) begin
                cr_seen <= 1'b1;
              end
              echo_eol <= 1'b1;
              state    <= S_ECHO;
            end else if (lt) begin
              count  <= inc;
              byte_q <= in_byte;
              state  <= S_CHAR;
            end else begin
              // line full: byte dropped
            end
          end
        end
        S_CHAR: begin
          if (take) begin
            state <= S_IDLE;
          end
        end
        S_ECHO: begin
          if (take) begin
            if (inc_eq) begin
              idx <= '0;
              if (!echo_eol) begin
                state <= S_IDLE;
              end else if (count == '0) begin
                state <= S_MARK;
              end else begin
                state <= S_LINE;
              end
            end else begin
              idx <= inc;
            end
          end
        end
        S_LINE: begin
          if (take) begin
            if (inc_eq) begin
              state <= S_MARK;
            end else begin
              idx <= inc;
            end
          end
        end
        S_MARK: begin
          if (take) begin
            count <= '0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/tb_console_line_editor.sv =====
// ----------------------------------------------------------------------------
// tb_console_line_editor - self-checking bench for the console line editor
// Feeds received bytes on the request stream, predicts every echo, line byte
// and end marker in a shadow of the line state, and checks each result in
// order. Directed editing and capacity cases come first, then random lines.
// ----------------------------------------------------------------------------
module tb_console_line_editor
  import cle_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Generous ceiling: the slowest legal run is far below this.
  localparam int CYCLE_LIMIT  = 1_500_000;
  // Quiet time after the last expected result; covers a swallowed LF or a
  // dropped byte still in flight.
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       ch;
    logic [CNT_W-1:0] len;
    logic             last;
  } line_out_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [15:0]      m_axis_tdata;
  logic [1:0]       m_axis_tuser;
  logic             m_axis_tlast;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CAP_W-1:0] cfg_data;

  // Shadow of the editor state, updated as each request is taken.
  logic [7:0]       shadow_line [LINE_DEPTH];
  int               shadow_count;
  logic             shadow_cr;
  logic [CAP_W-1:0] shadow_cap;

  line_out_t due_q[$];   // results still owed by the editor, oldest first
  int        errors = 0;
  int        sent_count;
  int        cycles = 0;
  bit        tx_bursts;  // allow gaps between requests
  bit        rx_bursts;  // allow stalls on the result side

  console_line_editor u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic void owe(input logic [1:0] kind, input logic [7:0] ch,
                              input logic [CNT_W-1:0] len);
    line_out_t r;
    r.kind = kind;
    r.ch   = ch;
    r.len  = len;
    r.last = 1'b0;
    due_q.push_back(r);
  endfunction

  // Bytes the line may hold: capacity less the terminator slot, never beyond
  // what the store and the length field allow.
  function automatic int room_limit();
    int lim;
    lim = (shadow_cap == '0) ? 0 : int'(shadow_cap) - 1;
    if (lim > LIMIT_MAX) lim = LIMIT_MAX;
    return lim;
  endfunction

  // Apply one received byte to the shadow and queue what it must produce.
  function automatic void edit_byte(input logic [7:0] c);
    int        owed_before;
    line_out_t tail;
    owed_before = due_q.size();
    if (c == CH_BS) begin
      // rubout; nothing at all on an empty line
      if (shadow_count != 0) begin
        owe(KIND_ECHO, CH_BS, '0);
        owe(KIND_ECHO, CH_SP, '0);
        owe(KIND_ECHO, CH_BS, '0);
        shadow_count--;
      end
    end else if (c == CH_LF && shadow_cr) begin
      // LF of a CR LF pair is swallowed silently
      shadow_cr = 1'b0;
    end else if (c == CH_CR || c == CH_LF || c == CH_ESC) begin
      // only CR arms the sticky flag; ESC and a lone LF leave it alone
      if (c == CH_CR) shadow_cr = 1'b1;
      owe(KIND_ECHO, CH_CR, '0);
      owe(KIND_ECHO, CH_CR, '0);
      owe(KIND_ECHO, CH_LF, '0);
      for (int i = 0; i < shadow_count; i++) owe(KIND_LINE, shadow_line[i], '0);
      owe(KIND_MARK, 8'h00, CNT_W'(shadow_count));
      shadow_count = 0;
    end else if (shadow_count < room_limit()) begin
      shadow_line[shadow_count] = c;
      shadow_count++;
      owe(KIND_ECHO, c, '0);
    end
    // tag the final result of this request
    if (due_q.size() > owed_before) begin
      tail      = due_q.pop_back();
      tail.last = 1'b1;
      due_q.push_back(tail);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking: every accepted result against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    line_out_t exp_r;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (due_q.size() == 0) begin
        $error("unexpected result: kind %0d byte 0x%02h len %0d last %0b",
               m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[12:8], m_axis_tlast);
        errors++;
      end else begin
        exp_r = due_q.pop_front();
        if (m_axis_tuser !== exp_r.kind) begin
          $error("kind: expected %0d, got %0d", exp_r.kind, m_axis_tuser);
          errors++;
        end
        if (m_axis_tdata[7:0] !== exp_r.ch) begin
          $error("out_byte: expected 0x%02h, got 0x%02h", exp_r.ch, m_axis_tdata[7:0]);
          errors++;
        end
        if (m_axis_tdata[12:8] !== exp_r.len) begin
          $error("line_length: expected %0d, got %0d", exp_r.len, m_axis_tdata[12:8]);
          errors++;
        end
        if (m_axis_tdata[15:13] !== 3'b000) begin
          $error("tdata pad: expected 0, got %0d", m_axis_tdata[15:13]);
          errors++;
        end
        if (m_axis_tlast !== exp_r.last) begin
          $error("last: expected %0b, got %0b", exp_r.last, m_axis_tlast);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result-side back-pressure: random stall bursts while enabled
  // ---------------------------------------------------------------------------
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_bursts && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // One request; entered and left at a falling edge. tvalid stays high from
  // one request to the next unless a gap is drawn.
  task automatic send_byte(input logic [7:0] b);
    if (tx_bursts && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    edit_byte(b);
    sent_count++;
    @(negedge clk);
  endtask

  // Stop requesting and let the editor run dry.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (due_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    shadow_cap = cap;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Any byte that is not an editing control.
  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == CH_BS || b == CH_CR || b == CH_LF || b == CH_ESC);
    return b;
  endfunction

  function automatic logic [CAP_W-1:0] pick_capacity();
    case ($urandom_range(0, 7))
      0:       return CAP_W'(0);
      1:       return CAP_W'(1);
      2:       return '1;          // far past the store, saturates
      3:       return CAP_W'(32);
      4:       return CAP_W'($urandom_range(0, 63));
      default: return CAP_W'($urandom_range(2, 12));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Basic editing at the reset capacity: storing, rubout, every line ending
  // and the sticky CR flag.
  task automatic test_editing();
    write_capacity(CAP_W'(32));
    send_byte(8'h61);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(CH_BS);
    send_byte(CH_BS);
    send_byte(CH_BS);
    send_byte(CH_BS);      // rubout on an empty line does nothing
    send_byte(8'h7F);
    send_byte(CH_CR);      // ends line, arms the flag
    send_byte(CH_LF);      // swallowed, clears the flag
    send_byte(CH_LF);      // lone LF ends an empty line
    send_byte(8'h80);
    send_byte(CH_ESC);     // ESC ends the line without the flag
    send_byte(CH_LF);      // flag still clear: another empty line
    send_byte(8'h55);
    send_byte(CH_CR);
    send_byte(8'h41);      // flag survives ordinary bytes
    send_byte(CH_BS);      // ...and rubout
    send_byte(8'hAA);
    send_byte(CH_LF);      // swallowed although the line is not empty
    send_byte(CH_ESC);     // ends the line holding 0xAA
  endtask

  // Fill past the limit at the capacity extremes, then end the line.
  task automatic fill_line(input logic [CAP_W-1:0] cap, input int n, input logic [7:0] term);
    write_capacity(cap);
    for (int i = 0; i < n; i++) send_byte(text_byte());
    send_byte(term);
  endtask

  task automatic test_capacity_limits();
    fill_line(CAP_W'(0), 3, CH_CR);      // no room at all
    fill_line(CAP_W'(1), 3, CH_LF);      // room only for the terminator
    fill_line(CAP_W'(2), 3, CH_ESC);     // one byte held
    write_capacity(CAP_W'(2));
    send_byte(text_byte());
    send_byte(CH_BS);                    // freed slot can be used again
    send_byte(text_byte());
    send_byte(text_byte());              // dropped
    send_byte(CH_ESC);
    fill_line(CAP_W'(31), 33, CH_ESC);   // 30 held
    fill_line('1, 34, CH_CR);            // saturates at 31: longest line end
    fill_line(CAP_W'(32), 33, CH_ESC);
  endtask

  // Mostly well-formed lines with random text, rubouts and line endings, and
  // some noise; with bursts on, the capacity and the idling change between lines.
  task automatic test_random_lines(input int n_items, input bit bursts);
    int stop_at;
    int len;
    stop_at = sent_count + n_items;
    while (sent_count < stop_at) begin
      if (bursts && $urandom_range(0, 7) == 0) write_capacity(pick_capacity());
      tx_bursts = bursts && ($urandom_range(0, 3) != 0);
      rx_bursts = bursts && ($urandom_range(0, 3) != 0);
      len = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 10);
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(0, 19))
          0, 1:    send_byte(CH_BS);
          2:       send_byte(8'($urandom_range(0, 255)));
          default: send_byte(text_byte());
        endcase
      end
      case ($urandom_range(0, 6))
        0, 1: begin
          send_byte(CH_CR);
          send_byte(CH_LF);
        end
        2:       send_byte(CH_CR);
        3:       send_byte(CH_LF);
        4:       send_byte(CH_ESC);
        5: begin
          send_byte(CH_CR);
          send_byte(CH_CR);
          send_byte(CH_LF);
        end
        default: ;                       // line runs on into the next one
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    sent_count    = 0;
    tx_bursts     = 1'b1;
    rx_bursts     = 1'b1;
    shadow_count  = 0;
    shadow_cr     = 1'b0;
    shadow_cap    = CAP_W'(32);
    for (int i = 0; i < LINE_DEPTH; i++) shadow_line[i] = '0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_editing();
    test_capacity_limits();
    test_random_lines(280, 1'b1);
    // closing stretch at full rate on both sides
    test_random_lines(60, 1'b0);

    s_axis_tvalid <= 1'b0;
    while (due_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
